// File: src/qsu_pkg.sv
`default_nettype none
package qsu_pkg;

  typedef enum logic [2:0] {
    K_DATA   = 3'd0,
    K_BADHEX = 3'd1,
    K_BADCP  = 3'd2,
    K_CLOSED = 3'd3,
    K_UNTERM = 3'd4,
    K_NOTSTR = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_Q1      = 3'd1,
    PH_Q2      = 3'd2,
    PH_MLSTART = 3'd3,
    PH_SL      = 3'd4,
    PH_ML      = 3'd5
  } phase_t;

  localparam int unsigned MAX_RES = 4;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       taken;
  } entry_t;

  // all results of one input word; cnt is 0 to MAX_RES (0 when the word yields none)
  typedef struct packed {
    logic [2:0]                cnt;
    entry_t [MAX_RES-1:0]      ent;
  } bundle_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_UU    = 8'h55;

  localparam logic [31:0] CP_SURR_LO = 32'h0000_D800;
  localparam logic [31:0] CP_SURR_HI = 32'h0000_DFFF;
  localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;
  localparam logic [31:0] CP_LIM1    = 32'h0000_0080;
  localparam logic [31:0] CP_LIM2    = 32'h0000_0800;
  localparam logic [31:0] CP_LIM3    = 32'h0001_0000;
  localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF_LEAD4  = 8'hF0;
  localparam logic [7:0]  UTF_CONT   = 8'h80;

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

endpackage
`default_nettype wire

// File: src/qsu_front.sv
`default_nettype none
module qsu_front import qsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic       in_action,
  input  wire logic [7:0] in_byte,
  output bundle_t         bnd,
  output logic            bnd_push
);

  phase_t      ph_r, ph_nxt;
  logic        esc_r, esc_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  hcnt_r, hcnt_nxt;
  logic [3:0]  need_r, need_nxt;
  logic [1:0]  held_r, held_nxt;
  logic        skip_r, skip_nxt;
  logic        clr;

  logic        is_quote;
  logic        ml;
  logic [4:0]  hv;
  logic [31:0] cp;
  logic [3:0]  cnt_inc;
  logic        body;
  logic [2:0]  n;

  function automatic entry_t mk(input kind_t k, input logic [7:0] d, input logic t);
    entry_t e;
    e.kind  = k;
    e.data  = d;
    e.taken = t;
    return e;
  endfunction

  assign is_quote = (in_byte == CH_QUOTE);
  assign ml       = (ph_r == PH_ML) || (ph_r == PH_MLSTART);
  assign hv       = hex_val(in_byte);
  assign cp       = {acc_r[27:0], hv[3:0]};
  assign cnt_inc  = hcnt_r + 4'd1;

  // datapath step and result words
  always_comb begin
    esc_nxt  = esc_r;
    acc_nxt  = acc_r;
    hcnt_nxt = hcnt_r;
    need_nxt = need_r;
    held_nxt = held_r;
    skip_nxt = skip_r;
    clr      = 1'b0;
    body     = 1'b0;
    n        = 3'd0;
    bnd      = '0;

    if (in_action) begin
      clr = 1'b1;
      unique case (ph_r)
        PH_Q1: begin
          bnd.ent[n[1:0]] = mk(K_UNTERM, 8'h00, 1'b0); n = n + 3'd1;
        end
        PH_Q2: begin
          bnd.ent[n[1:0]] = mk(K_CLOSED, 8'h00, 1'b0); n = n + 3'd1;
        end
        PH_MLSTART, PH_SL, PH_ML: begin
          if (need_r != 4'd0) begin
            bnd.ent[n[1:0]] = mk(K_BADHEX, 8'h00, 1'b0); n = n + 3'd1;
          end
          bnd.ent[n[1:0]] = mk(K_UNTERM, 8'h00, 1'b0); n = n + 3'd1;
        end
        default: begin
          bnd.ent[n[1:0]] = mk(K_NOTSTR, 8'h00, 1'b0); n = n + 3'd1;
        end
      endcase
    end else begin
      unique case (ph_r)
        PH_Q1:      body = !is_quote;
        PH_Q2: begin
          if (!is_quote) begin
            clr = 1'b1;
            bnd.ent[n[1:0]] = mk(K_CLOSED, 8'h00, 1'b0); n = n + 3'd1;
          end
        end
        PH_MLSTART: body = (in_byte != CH_LF);
        PH_SL, PH_ML: begin
          if (need_r == 4'd0) begin
            body = 1'b1;
          end else if (hv[4]) begin
            acc_nxt  = cp;
            hcnt_nxt = cnt_inc;
            if (cnt_inc >= need_r) begin
              acc_nxt  = '0;
              hcnt_nxt = '0;
              need_nxt = '0;
              if ((cp >= CP_SURR_LO && cp <= CP_SURR_HI) || cp > CP_MAX) begin
                bnd.ent[n[1:0]] = mk(K_BADCP, 8'h00, 1'b0); n = n + 3'd1;
              end else if (cp < CP_LIM1) begin
                bnd.ent[n[1:0]] = mk(K_DATA, cp[7:0], 1'b0); n = n + 3'd1;
              end else if (cp < CP_LIM2) begin
                bnd.ent[n[1:0]] = mk(K_DATA, UTF_LEAD2 | {3'b0, cp[10:6]}, 1'b0);
                n = n + 3'd1;
                bnd.ent[n[1:0]] = mk(K_DATA, UTF_CONT | {2'b0, cp[5:0]}, 1'b0);
                n = n + 3'd1;
              end else if (cp < CP_LIM3) begin
                bnd.ent[n[1:0]] = mk(K_DATA, UTF_LEAD3 | {4'b0, cp[15:12]}, 1'b0);
                n = n + 3'd1;
                bnd.ent[n[1:0]] = mk(K_DATA, UTF_CONT | {2'b0, cp[11:6]}, 1'b0);
                n = n + 3'd1;
                bnd.ent[n[1:0]] = mk(K_DATA, UTF_CONT | {2'b0, cp[5:0]}, 1'b0);
                n = n + 3'd1;
              end else begin
                bnd.ent[n[1:0]] = mk(K_DATA, UTF_LEAD4 | {5'b0, cp[20:18]}, 1'b0);
                n = n + 3'd1;
                bnd.ent[n[1:0]] = mk(K_DATA, UTF_CONT | {2'b0, cp[17:12]}, 1'b0);
                n = n + 3'd1;
                bnd.ent[n[1:0]] = mk(K_DATA, UTF_CONT | {2'b0, cp[11:6]}, 1'b0);
                n = n + 3'd1;
                bnd.ent[n[1:0]] = mk(K_DATA, UTF_CONT | {2'b0, cp[5:0]}, 1'b0);
                n = n + 3'd1;
              end
            end
          end else begin
            // short hex escape: flag it, then treat the byte normally
            bnd.ent[n[1:0]] = mk(K_BADHEX, 8'h00, 1'b0); n = n + 3'd1;
            need_nxt = '0;
            hcnt_nxt = '0;
            acc_nxt  = '0;
            body     = 1'b1;
          end
        end
        default: begin
          clr = 1'b1;
          if (!is_quote) begin
            bnd.ent[n[1:0]] = mk(K_NOTSTR, 8'h00, 1'b0); n = n + 3'd1;
          end
        end
      endcase

      if (body) begin
        if (esc_r) begin
          esc_nxt = 1'b0;
          unique case (in_byte)
            CH_N: begin bnd.ent[n[1:0]] = mk(K_DATA, CH_LF, 1'b0); n = n + 3'd1; end
            CH_T: begin bnd.ent[n[1:0]] = mk(K_DATA, CH_TAB, 1'b0); n = n + 3'd1; end
            CH_R: begin bnd.ent[n[1:0]] = mk(K_DATA, CH_CR, 1'b0); n = n + 3'd1; end
            CH_B: begin bnd.ent[n[1:0]] = mk(K_DATA, CH_BS, 1'b0); n = n + 3'd1; end
            CH_F: begin bnd.ent[n[1:0]] = mk(K_DATA, CH_FF, 1'b0); n = n + 3'd1; end
            CH_LU, CH_UU: begin
              need_nxt = (in_byte == CH_LU) ? 4'd4 : 4'd8;
              hcnt_nxt = '0;
              acc_nxt  = '0;
            end
            CH_LF, CH_CR: begin
              if (ml) begin
                skip_nxt = 1'b1;
              end else begin
                clr = 1'b1;
                bnd.ent[n[1:0]] = mk(K_UNTERM, 8'h00, 1'b0); n = n + 3'd1;
              end
            end
            default: begin
              bnd.ent[n[1:0]] = mk(K_DATA, in_byte, 1'b0); n = n + 3'd1;
            end
          endcase
        end else if (ml) begin
          if (skip_r && (in_byte == CH_SPACE || in_byte == CH_TAB ||
                         in_byte == CH_LF || in_byte == CH_CR)) begin
            skip_nxt = 1'b1;
          end else begin
            skip_nxt = 1'b0;
            if (is_quote) begin
              if (held_r >= 2'd2) begin
                clr = 1'b1;
                bnd.ent[n[1:0]] = mk(K_CLOSED, 8'h00, 1'b1); n = n + 3'd1;
              end else begin
                held_nxt = held_r + 2'd1;
              end
            end else begin
              // flush quotes that did not make a closing triple
              if (held_r != 2'd0) begin
                bnd.ent[n[1:0]] = mk(K_DATA, CH_QUOTE, 1'b0); n = n + 3'd1;
              end
              if (held_r >= 2'd2) begin
                bnd.ent[n[1:0]] = mk(K_DATA, CH_QUOTE, 1'b0); n = n + 3'd1;
              end
              held_nxt = '0;
              if (in_byte == CH_BSL) begin
                esc_nxt = 1'b1;
              end else begin
                bnd.ent[n[1:0]] = mk(K_DATA, in_byte, 1'b0); n = n + 3'd1;
              end
            end
          end
        end else begin
          priority if (is_quote) begin
            clr = 1'b1;
            bnd.ent[n[1:0]] = mk(K_CLOSED, 8'h00, 1'b1); n = n + 3'd1;
          end else if (in_byte == CH_LF || in_byte == CH_CR) begin
            clr = 1'b1;
            bnd.ent[n[1:0]] = mk(K_UNTERM, 8'h00, 1'b0); n = n + 3'd1;
          end else if (in_byte == CH_BSL) begin
            esc_nxt = 1'b1;
          end else begin
            bnd.ent[n[1:0]] = mk(K_DATA, in_byte, 1'b0); n = n + 3'd1;
          end
        end
      end
    end

    if (clr) begin
      esc_nxt  = 1'b0;
      acc_nxt  = '0;
      hcnt_nxt = '0;
      need_nxt = '0;
      held_nxt = '0;
      skip_nxt = 1'b0;
    end

    bnd.cnt  = n;
    bnd_push = acc && (n != 3'd0);
  end

  // phase next state
  always_comb begin
    ph_nxt = ph_r;
    if (in_action) begin
      ph_nxt = PH_IDLE;
    end else begin
      unique case (ph_r)
        PH_Q1:        ph_nxt = is_quote ? PH_Q2 : (clr ? PH_IDLE : PH_SL);
        PH_Q2:        ph_nxt = is_quote ? PH_MLSTART : PH_IDLE;
        PH_MLSTART:   ph_nxt = clr ? PH_IDLE : PH_ML;
        PH_SL, PH_ML: ph_nxt = clr ? PH_IDLE : ph_r;
        default:      ph_nxt = is_quote ? PH_Q1 : PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      esc_r  <= 1'b0;
      acc_r  <= '0;
      hcnt_r <= '0;
      need_r <= '0;
      held_r <= '0;
      skip_r <= 1'b0;
    end else if (acc) begin
      ph_r   <= ph_nxt;
      esc_r  <= esc_nxt;
      acc_r  <= acc_nxt;
      hcnt_r <= hcnt_nxt;
      need_r <= need_nxt;
      held_r <= held_nxt;
      skip_r <= skip_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/qsu_fifo.sv
`default_nettype none
module qsu_fifo import qsu_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire bundle_t wdata,
  input  wire logic    pop,
  output bundle_t      rdata,
  output logic         full,
  output logic         empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  bundle_t [DEPTH-1:0] mem_r;
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)      cnt_nxt = cnt_r + CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + PW'(1);
      if (pop)  rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + PW'(1);
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/qsu_back.sv
`default_nettype none
module qsu_back import qsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire bundle_t    head,
  input  wire logic       head_valid,
  output logic            head_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            out_input_taken,
  output logic            out_last
);

  logic [1:0] idx_r, idx_nxt;
  entry_t     cur;
  logic       fire;

  assign cur             = head.ent[idx_r];
  assign out_valid       = head_valid;
  assign out_kind        = cur.kind;
  assign out_byte        = cur.data;
  assign out_input_taken = cur.taken;
  assign out_last        = ({1'b0, idx_r} == (head.cnt - 3'd1));
  assign fire            = out_valid && out_ready;
  assign head_pop        = fire && out_last;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) idx_nxt = out_last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else        idx_r <= idx_nxt;
  end

endmodule
`default_nettype wire

// File: src/quoted_string_unescape.sv
// Output: each input word's results are registered in the bundle queue and offered on out_*.
// Throughput: one input word per cycle while in_ready is high; the result side delivers one
//   word per cycle while out_ready is high, so a word with n results (up to four, e.g. a 4-byte
//   UTF-8 sequence) holds the back end; FIFO_DEPTH bundles absorb it before in_ready drops.
// Reset: synchronous, active low; the decoder returns to idle and the queue empties.
`default_nettype none
module quoted_string_unescape import qsu_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       in_action,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_byte,
  output logic            out_input_taken,
  output logic            out_last
);

  bundle_t wr_bnd, head;
  logic    push, pop, full, empty;
  logic    in_acc;

  // ready depends only on queue occupancy, never on out_ready
  assign in_ready = !full;
  assign in_acc   = in_valid && in_ready;

  // front end: decoder state machine, packs a word's results into one bundle
  qsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .in_action (in_action),
    .in_byte   (in_byte),
    .bnd       (wr_bnd),
    .bnd_push  (push)
  );

  // bundles with no results (absorbed bytes) are never queued
  qsu_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (wr_bnd),
    .pop   (pop),
    .rdata (head),
    .full  (full),
    .empty (empty)
  );

  // back end: serialises each bundle, one result word per handshake
  qsu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .head_valid      (!empty),
    .head_pop        (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_input_taken (out_input_taken),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

// File: src/qsu_checker.sv
`default_nettype none
module qsu_checker import qsu_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_action,
  input wire logic [7:0] in_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic       out_input_taken,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte) &&
      $stable(out_last) && $stable(out_input_taken))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == K_CLOSED || out_kind == K_UNTERM || out_kind == K_NOTSTR)
      |-> out_last)
    else $error("string end not marked last");

  a_taken_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_input_taken |-> out_kind == K_CLOSED)
    else $error("input_taken on a non-closing word");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_DATA |-> out_byte == 8'h00)
    else $error("status word carries a byte");

endmodule

bind quoted_string_unescape qsu_checker u_qsu_checker (.*);
`default_nettype wire
